// File: rtl/gba_pkg.sv
// Shared types, constants and controller/datapath interface for the grouped bitmap allocator.
package gba_pkg;

	localparam int MAX_GROUPS    = 8;
	localparam int BITMAP_BITS   = 1024;
	localparam int WORD_W        = 32;
	localparam int GRP_W         = $clog2(MAX_GROUPS);
	localparam int BIT_W         = $clog2(WORD_W);
	localparam int WORDS_PER_GRP = BITMAP_BITS / WORD_W;
	localparam int WIDX_W        = $clog2(WORDS_PER_GRP);
	localparam int ROWS          = MAX_GROUPS * WORDS_PER_GRP;
	localparam int ROW_W         = GRP_W + WIDX_W;
	localparam int LIM_W         = $clog2(BITMAP_BITS) + 1;

	localparam int OP_W    = 2;
	localparam int SEL_W   = 4;
	localparam int ID_W    = 14;
	localparam int CNT_W   = 16;
	localparam int PGC_W   = 11;
	localparam int GCNT_W  = 4;
	localparam int TOT_W   = 14;
	localparam int CFGI_W  = 2;
	localparam int CFGD_W  = 14;
	localparam int GLIM_W  = 7;

	localparam logic [GLIM_W-1:0] GRP_LIMIT = GLIM_W'(MAX_GROUPS);

	localparam logic [PGC_W-1:0]  PGC_RESET  = PGC_W'(1024);
	localparam logic [GCNT_W-1:0] GCNT_RESET = GCNT_W'(8);
	localparam logic [TOT_W-1:0]  TOT_RESET  = TOT_W'(8192);

	typedef enum logic [CFGI_W-1:0] {
		CFG_PER_GROUP = 2'd0,
		CFG_GROUPS    = 2'd1,
		CFG_TOTAL     = 2'd2
	} cfg_idx_t;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC  = 2'd0,
		OP_FREE   = 2'd1,
		OP_PRESET = 2'd2,
		OP_RSVD   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NONE    = 2'd1,
		ST_INVALID = 2'd2
	} status_t;

	typedef struct packed {
		logic    load;
		logic    scan_next_grp;
		logic    grp_latch;
		logic    lim_latch;
		logic    word_next;
		logic    mem_rd;
		logic    alloc_commit;
		logic    div_step;
		logic    free_commit;
		logic    preset_commit;
		logic    res_en;
		status_t res_status;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic pgc_zero;
		logic ident_zero;
		logic sel_ok;
		logic scan_done;
		logic grp_ok;
		logic words_done;
		logic hit;
		logic div_done;
		logic div_over;
		logic free_ok;
	} stat_t;

endpackage

// File: rtl/grouped_bitmap_id_allocator.sv
// Top level of the grouped bitmap identifier allocator.
//
//   channel   direction  handshake                    payload
//   command   in         start, taken when !busy      op, group_sel, ident, count_value
//   result    out        done, one cycle, no stall    status, granted, group_free
//   config    in         cfg_we, taken every edge     cfg_idx, cfg_data
//
// A word is accepted at a rising edge with start high and busy low; one result follows.
// Preset, unused op and early rejects: the result is given from the dispatch state.
// Free: repeated subtraction finds the group q (a reject ends the division), then the word is read and cleared.
// Allocate: groups are tried in rotation from the selected one; a usable group has its scan limit latched,
//   then its bitmap words are read and checked in turn; if no group has a free bit, the result is status none.
// Reset clears the bitmap at once through per-row valid bits; no clearing pass.
module grouped_bitmap_id_allocator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [gba_pkg::OP_W-1:0]   op,
	input  logic [gba_pkg::SEL_W-1:0]  group_sel,
	input  logic [gba_pkg::ID_W-1:0]   ident,
	input  logic [gba_pkg::CNT_W-1:0]  count_value,
	input  logic                       cfg_we,
	input  logic [gba_pkg::CFGI_W-1:0] cfg_idx,
	input  logic [gba_pkg::CFGD_W-1:0] cfg_data,
	output logic                       done,
	output logic [1:0]                 status,
	output logic [gba_pkg::ID_W-1:0]   granted,
	output logic [gba_pkg::CNT_W-1:0]  group_free
);

	gba_pkg::cmd_t  cmd;
	gba_pkg::stat_t stat;

	gba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	gba_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.op          (op),
		.group_sel   (group_sel),
		.ident       (ident),
		.count_value (count_value),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.done        (done),
		.status      (status),
		.granted     (granted),
		.group_free  (group_free)
	);

endmodule

// File: rtl/gba_datapath.sv
// Datapath: configuration, bitmap memory, free counts, group scan and division unit.
module gba_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  gba_pkg::cmd_t              cmd,
	output gba_pkg::stat_t             stat,
	input  logic [gba_pkg::OP_W-1:0]   op,
	input  logic [gba_pkg::SEL_W-1:0]  group_sel,
	input  logic [gba_pkg::ID_W-1:0]   ident,
	input  logic [gba_pkg::CNT_W-1:0]  count_value,
	input  logic                       cfg_we,
	input  logic [gba_pkg::CFGI_W-1:0] cfg_idx,
	input  logic [gba_pkg::CFGD_W-1:0] cfg_data,
	output logic                       done,
	output logic [1:0]                 status,
	output logic [gba_pkg::ID_W-1:0]   granted,
	output logic [gba_pkg::CNT_W-1:0]  group_free
);

	logic [gba_pkg::PGC_W-1:0]  pgc_q;
	logic [gba_pkg::GCNT_W-1:0] gcnt_q;
	logic [gba_pkg::TOT_W-1:0]  total_q;

	gba_pkg::op_t               op_q;
	logic [gba_pkg::SEL_W-1:0]  sel_q;
	logic [gba_pkg::CNT_W-1:0]  cv_q;
	logic [gba_pkg::ID_W-1:0]   rem_q;
	logic [gba_pkg::GCNT_W-1:0] n_q;
	logic [gba_pkg::GRP_W-1:0]  g_q;
	logic [gba_pkg::TOT_W-1:0]  base_q;
	logic [gba_pkg::LIM_W-1:0]  lim_q;
	logic [gba_pkg::WIDX_W:0]   w_q;

	logic [gba_pkg::WORD_W-1:0] mem [gba_pkg::ROWS];
	logic [gba_pkg::ROWS-1:0]   row_valid_q;
	logic [gba_pkg::WORD_W-1:0] rd_q;
	logic                       rv_q;

	logic [gba_pkg::CNT_W-1:0]  cnt_q [gba_pkg::MAX_GROUPS];

	logic                       done_q;
	gba_pkg::status_t           status_q;
	logic [gba_pkg::ID_W-1:0]   granted_q;
	logic [gba_pkg::CNT_W-1:0]  gfree_q;

	logic [gba_pkg::GCNT_W-1:0] span;
	logic [gba_pkg::GCNT_W-1:0] start_grp;
	logic [gba_pkg::GCNT_W:0]   sum;
	logic [gba_pkg::GCNT_W:0]   gsum;
	logic [gba_pkg::TOT_W-1:0]  headroom;
	logic [gba_pkg::TOT_W-1:0]  lim_wide;
	logic [gba_pkg::LIM_W-1:0]  lim_nx;
	logic [gba_pkg::LIM_W:0]    wlim_sum;
	logic [gba_pkg::WIDX_W:0]   wlim;
	logic [gba_pkg::LIM_W-1:0]  word_rem;
	logic [gba_pkg::WORD_W-1:0] eff;
	logic [gba_pkg::WORD_W-1:0] mask;
	logic [gba_pkg::WORD_W-1:0] avail;
	logic [gba_pkg::BIT_W-1:0]  bitpos;
	logic [gba_pkg::BIT_W-1:0]  fbit;
	logic                       bit_set;
	logic [gba_pkg::WORD_W-1:0] alloc_word;
	logic [gba_pkg::WORD_W-1:0] free_word;
	logic [gba_pkg::WORD_W-1:0] wr_word;
	logic                       wr_en;
	logic [gba_pkg::ROW_W-1:0]  addr;
	logic [gba_pkg::CNT_W-1:0]  cur_cnt;
	logic [gba_pkg::CNT_W-1:0]  alloc_cnt;
	logic [gba_pkg::CNT_W-1:0]  free_cnt;
	logic [gba_pkg::ID_W-1:0]   grant;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pgc_q   <= gba_pkg::PGC_RESET;
			gcnt_q  <= gba_pkg::GCNT_RESET;
			total_q <= gba_pkg::TOT_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				gba_pkg::CFG_PER_GROUP: pgc_q   <= cfg_data[gba_pkg::PGC_W-1:0];
				gba_pkg::CFG_GROUPS:    gcnt_q  <= cfg_data[gba_pkg::GCNT_W-1:0];
				gba_pkg::CFG_TOTAL:     total_q <= cfg_data[gba_pkg::TOT_W-1:0];
				default: ;
			endcase
		end
	end

	// group rotation
	always_comb begin
		span      = (gcnt_q == '0) ? gba_pkg::GCNT_W'(1) : gcnt_q;
		start_grp = (sel_q < span) ? sel_q : '0;
		sum       = {1'b0, start_grp} + {1'b0, n_q};
		gsum      = (sum >= {1'b0, span}) ? (sum - {1'b0, span}) : sum;
	end

	// scan limit of the current group
	always_comb begin
		headroom = (total_q > base_q) ? (total_q - base_q) : '0;
		lim_wide = gba_pkg::TOT_W'(pgc_q);
		if (lim_wide > gba_pkg::TOT_W'(gba_pkg::BITMAP_BITS)) begin
			lim_wide = gba_pkg::TOT_W'(gba_pkg::BITMAP_BITS);
		end
		if (headroom < lim_wide) begin
			lim_wide = headroom;
		end
		lim_nx   = gba_pkg::LIM_W'(lim_wide);
		wlim_sum = {1'b0, lim_q} + (gba_pkg::LIM_W + 1)'(gba_pkg::WORD_W - 1);
		wlim     = (gba_pkg::WIDX_W + 1)'(wlim_sum >> gba_pkg::BIT_W);
		word_rem = lim_q - gba_pkg::LIM_W'({w_q, {gba_pkg::BIT_W{1'b0}}});
	end

	// word check
	always_comb begin
		eff = rv_q ? rd_q : '0;
		for (int b = 0; b < gba_pkg::WORD_W; b++) begin
			mask[b] = (gba_pkg::LIM_W'(b) < word_rem);
		end
		avail  = ~eff & mask;
		bitpos = '0;
		for (int b = gba_pkg::WORD_W - 1; b >= 0; b--) begin
			if (avail[b]) begin
				bitpos = gba_pkg::BIT_W'(b);
			end
		end
		fbit       = rem_q[gba_pkg::BIT_W-1:0];
		bit_set    = eff[fbit];
		alloc_word = eff | (gba_pkg::WORD_W'(1) << bitpos);
		free_word  = eff & ~(gba_pkg::WORD_W'(1) << fbit);
		wr_word    = (op_q == gba_pkg::OP_FREE) ? free_word : alloc_word;
		wr_en      = cmd.alloc_commit || (cmd.free_commit && bit_set);
		if (op_q == gba_pkg::OP_FREE) begin
			addr = {g_q, rem_q[gba_pkg::BIT_W +: gba_pkg::WIDX_W]};
		end else begin
			addr = {g_q, w_q[gba_pkg::WIDX_W-1:0]};
		end
		cur_cnt   = cnt_q[g_q];
		alloc_cnt = (cur_cnt == '0) ? '0 : (cur_cnt - gba_pkg::CNT_W'(1));
		free_cnt  = bit_set ? (cur_cnt + gba_pkg::CNT_W'(1)) : cur_cnt;
		grant     = base_q + gba_pkg::ID_W'({w_q[gba_pkg::WIDX_W-1:0], bitpos})
			+ gba_pkg::ID_W'(1);
	end

	// item and scan registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= gba_pkg::op_t'(op);
			sel_q <= group_sel;
			cv_q  <= count_value;
			rem_q <= ident - gba_pkg::ID_W'(1);
			n_q   <= '0;
			g_q   <= '0;
		end else if (cmd.scan_next_grp) begin
			n_q <= n_q + gba_pkg::GCNT_W'(1);
		end else if (cmd.grp_latch) begin
			g_q    <= gsum[gba_pkg::GRP_W-1:0];
			base_q <= gba_pkg::TOT_W'(gsum[gba_pkg::GRP_W-1:0]) * gba_pkg::TOT_W'(pgc_q);
		end else if (cmd.lim_latch) begin
			lim_q <= lim_nx;
			w_q   <= '0;
		end else if (cmd.word_next) begin
			w_q <= w_q + (gba_pkg::WIDX_W + 1)'(1);
		end else if (cmd.div_step) begin
			rem_q <= rem_q - gba_pkg::ID_W'(pgc_q);
			g_q   <= g_q + gba_pkg::GRP_W'(1);
		end
	end

	// bitmap memory
	always_ff @(posedge clk) begin
		if (cmd.mem_rd) begin
			rd_q <= mem[addr];
		end
		if (wr_en) begin
			mem[addr] <= wr_word;
		end
	end

	// row valid bits: an unwritten row reads as all free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rv_q        <= 1'b0;
		end else begin
			if (cmd.mem_rd) begin
				rv_q <= row_valid_q[addr];
			end
			if (wr_en) begin
				row_valid_q[addr] <= 1'b1;
			end
		end
	end

	// free counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < gba_pkg::MAX_GROUPS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (cmd.alloc_commit) begin
			cnt_q[g_q] <= alloc_cnt;
		end else if (cmd.free_commit) begin
			cnt_q[g_q] <= free_cnt;
		end else if (cmd.preset_commit) begin
			cnt_q[sel_q[gba_pkg::GRP_W-1:0]] <= cv_q;
		end
	end

	// result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.res_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_en) begin
			status_q  <= cmd.res_status;
			granted_q <= cmd.alloc_commit ? grant : '0;
			if (cmd.alloc_commit) begin
				gfree_q <= alloc_cnt;
			end else if (cmd.free_commit) begin
				gfree_q <= free_cnt;
			end else if (cmd.preset_commit) begin
				gfree_q <= cv_q;
			end else begin
				gfree_q <= '0;
			end
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign granted    = granted_q;
	assign group_free = gfree_q;

	always_comb begin
		stat.op         = op_q;
		stat.pgc_zero   = (pgc_q == '0);
		stat.ident_zero = &rem_q;
		stat.sel_ok     = (gba_pkg::GLIM_W'(sel_q) < gba_pkg::GRP_LIMIT);
		stat.scan_done  = (n_q >= span);
		stat.grp_ok     = (gsum < {1'b0, gcnt_q})
			&& (gba_pkg::GLIM_W'(gsum) < gba_pkg::GRP_LIMIT);
		stat.words_done = (w_q >= wlim);
		stat.hit        = |avail;
		stat.div_done   = (rem_q < gba_pkg::ID_W'(pgc_q));
		stat.div_over   = (g_q == gba_pkg::GRP_W'(gba_pkg::MAX_GROUPS - 1));
		stat.free_ok    = (gba_pkg::GLIM_W'(g_q) < gba_pkg::GLIM_W'(gcnt_q))
			&& (rem_q < gba_pkg::ID_W'(gba_pkg::BITMAP_BITS));
	end

endmodule

// File: rtl/gba_ctrl.sv
// Controller state machine sequencing allocate, free and preset over the datapath.
module gba_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  gba_pkg::stat_t stat,
	output gba_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_A_GRP,
		S_A_LIM,
		S_A_RD,
		S_A_CHK,
		S_F_DIV,
		S_F_CHK
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   busy_q;

	always_comb begin
		cmd            = '0;
		cmd.res_status = gba_pkg::ST_OK;
		state_nx       = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_nx = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (stat.op)
					gba_pkg::OP_ALLOC: begin
						if (stat.pgc_zero) begin
							cmd.res_en     = 1'b1;
							cmd.res_status = gba_pkg::ST_NONE;
							state_nx       = S_IDLE;
						end else begin
							state_nx = S_A_GRP;
						end
					end
					gba_pkg::OP_FREE: begin
						if (stat.pgc_zero || stat.ident_zero) begin
							cmd.res_en     = 1'b1;
							cmd.res_status = gba_pkg::ST_INVALID;
							state_nx       = S_IDLE;
						end else begin
							state_nx = S_F_DIV;
						end
					end
					gba_pkg::OP_PRESET: begin
						cmd.res_en = 1'b1;
						if (stat.sel_ok) begin
							cmd.preset_commit = 1'b1;
						end else begin
							cmd.res_status = gba_pkg::ST_INVALID;
						end
						state_nx = S_IDLE;
					end
					default: begin
						cmd.res_en     = 1'b1;
						cmd.res_status = gba_pkg::ST_INVALID;
						state_nx       = S_IDLE;
					end
				endcase
			end
			S_A_GRP: begin
				if (stat.scan_done) begin
					cmd.res_en     = 1'b1;
					cmd.res_status = gba_pkg::ST_NONE;
					state_nx       = S_IDLE;
				end else if (stat.grp_ok) begin
					cmd.grp_latch = 1'b1;
					state_nx      = S_A_LIM;
				end else begin
					cmd.scan_next_grp = 1'b1;
				end
			end
			S_A_LIM: begin
				cmd.lim_latch = 1'b1;
				state_nx      = S_A_RD;
			end
			S_A_RD: begin
				if (stat.words_done) begin
					cmd.scan_next_grp = 1'b1;
					state_nx          = S_A_GRP;
				end else begin
					cmd.mem_rd = 1'b1;
					state_nx   = S_A_CHK;
				end
			end
			S_A_CHK: begin
				if (stat.hit) begin
					cmd.alloc_commit = 1'b1;
					cmd.res_en       = 1'b1;
					state_nx         = S_IDLE;
				end else begin
					cmd.word_next = 1'b1;
					state_nx      = S_A_RD;
				end
			end
			S_F_DIV: begin
				if (stat.div_done) begin
					if (stat.free_ok) begin
						cmd.mem_rd = 1'b1;
						state_nx   = S_F_CHK;
					end else begin
						cmd.res_en     = 1'b1;
						cmd.res_status = gba_pkg::ST_INVALID;
						state_nx       = S_IDLE;
					end
				end else if (stat.div_over) begin
					cmd.res_en     = 1'b1;
					cmd.res_status = gba_pkg::ST_INVALID;
					state_nx       = S_IDLE;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_F_CHK: begin
				cmd.free_commit = 1'b1;
				cmd.res_en      = 1'b1;
				state_nx        = S_IDLE;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			busy_q  <= (state_nx != S_IDLE);
		end
	end

	assign busy = busy_q;

endmodule

// File: rtl/gba_checker.sv
// Port-level checker for the allocator, bound to the top level.
module gba_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic                      done,
	input logic [1:0]                status,
	input logic [gba_pkg::ID_W-1:0]  granted,
	input logic [gba_pkg::CNT_W-1:0] group_free
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) && !busy)
		else $error("result word outside a busy period");

	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && (granted != '0) |-> status == gba_pkg::ST_OK)
		else $error("identifier granted with failing status");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != gba_pkg::ST_OK) |-> (granted == '0) && (group_free == '0))
		else $error("failing result carries data");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == gba_pkg::ST_OK) || (status == gba_pkg::ST_NONE)
			|| (status == gba_pkg::ST_INVALID))
		else $error("unknown status code");

endmodule

bind grouped_bitmap_id_allocator gba_checker u_gba_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.status     (status),
	.granted    (granted),
	.group_free (group_free)
);
